@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

@@ src/mls_pkg.sv @@
`timescale 1ns / 1ps
package mls_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_STORE = 2'd1,
        REQ_REG   = 2'd2,
        REQ_BYTE  = 2'd3
    } t_req;

    localparam logic [1:0] KIND_RD_REG  = 2'd0;
    localparam logic [1:0] KIND_RD_BYTE = 2'd1;
    localparam logic [1:0] KIND_WR_BYTE = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    localparam logic [1:0] OC_RETIRE   = 2'd0;
    localparam logic [1:0] OC_REPEAT   = 2'd1;
    localparam logic [1:0] OC_REDIRECT = 2'd2;

    localparam logic [5:0] CAUSE_LOAD_MISALIGN  = 6'd4;
    localparam logic [5:0] CAUSE_STORE_MISALIGN = 6'd6;
    localparam logic [5:0] CAUSE_LOAD_ACCESS    = 6'd5;
    localparam logic [5:0] CAUSE_FETCH_ACCESS   = 6'd1;
    localparam logic [5:0] CAUSE_LOAD_PAGE      = 6'd13;
    localparam logic [5:0] CAUSE_FETCH_PAGE     = 6'd12;

    localparam logic [1:0] ADDR_XLEN = 2'd0;
    localparam logic [1:0] ADDR_FP   = 2'd1;
    localparam logic [1:0] ADDR_TLB  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] instr_word;
        logic [63:0] instr_addr;
        logic [63:0] fault_addr;
        logic        fault_flag;
        logic [5:0]  fault_cause;
        logic [63:0] reply_data;
    } t_in;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [4:0]  reg_index;
        logic        reg_is_fp;
        logic        reg_is_double;
        logic [63:0] access_addr;
        logic [7:0]  access_data;
        logic [1:0]  outcome;
        logic [63:0] new_pc;
        logic [5:0]  trap_cause;
        logic [63:0] trap_value;
        logic [63:0] load_value;
        logic        load_write;
    } t_out;

    // front to back queue entry
    typedef struct packed {
        t_in        item;
        logic       dec_ok;
        logic [1:0] size;
        logic       sign;
        logic       fp;
        logic [4:0] rreg;
        logic       short_i;
    } t_cmd;

    typedef struct packed {
        logic       xlen_is_64;
        logic [1:0] fp_mode;
        logic [5:0] tlb_miss_cause;
    } t_cfg;

endpackage

@@ src/mls_front.sv @@
`timescale 1ns / 1ps
module mls_front import mls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);
    logic        r_vld;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic [31:0] w;
    logic [15:0] f;
    logic [15:0] c;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [4:0]  crs;
    logic [4:0]  csp;
    logic        x64;
    logic        fps;
    logic        fpd;
    logic        ok;
    logic [1:0]  sz;
    logic        sg;
    logic        fp;
    logic [4:0]  rg;

    always_comb begin
        w   = (i_data.instr_word[1:0] != 2'b11) ? {16'd0, i_data.instr_word[15:0]}
                                                  : i_data.instr_word;
        f   = w[15:0] & 16'h707f;
        c   = w[15:0] & 16'he003;
        rd  = w[11:7];
        rs2 = w[24:20];
        crs = {2'b01, w[4:2]};
        csp = w[6:2];
        x64 = i_cfg.xlen_is_64;
        fps = i_cfg.fp_mode != 2'd0;
        fpd = i_cfg.fp_mode >= 2'd2;
        ok = 1'b1; sz = 2'd0; sg = 1'b0; fp = 1'b0; rg = 5'd0;
        if (i_data.req_type == REQ_LOAD) begin
            if (f == 16'h2003) begin sz = 2'd2; sg = 1'b1; rg = rd; end
            else if (x64 && f == 16'h3003) begin sz = 2'd3; sg = 1'b1; rg = rd; end
            else if (x64 && f == 16'h6003) begin sz = 2'd2; rg = rd; end
            else if (fpd && f == 16'h3007) begin sz = 2'd3; fp = 1'b1; rg = rd; end
            else if (fps && f == 16'h2007) begin sz = 2'd2; fp = 1'b1; rg = rd; end
            else if (f == 16'h1003) begin sz = 2'd1; sg = 1'b1; rg = rd; end
            else if (f == 16'h5003) begin sz = 2'd1; rg = rd; end
            else if (x64 && c == 16'h6000) begin sz = 2'd3; sg = 1'b1; rg = crs; end
            else if (x64 && c == 16'h6002 && rd != 5'd0) begin
                sz = 2'd3; sg = 1'b1; rg = rd;
            end
            else if (c == 16'h4000) begin sz = 2'd2; sg = 1'b1; rg = crs; end
            else if (c == 16'h4002 && rd != 5'd0) begin sz = 2'd2; sg = 1'b1; rg = rd; end
            else if (fpd && c == 16'h2000) begin sz = 2'd3; fp = 1'b1; rg = crs; end
            else if (fpd && c == 16'h2002) begin sz = 2'd3; fp = 1'b1; rg = rd; end
            else if (!x64 && fps && c == 16'h6000) begin sz = 2'd2; fp = 1'b1; rg = crs; end
            else if (!x64 && fps && c == 16'h6002) begin sz = 2'd2; fp = 1'b1; rg = rd; end
            else ok = 1'b0;
        end else begin
            if (f == 16'h2023) begin sz = 2'd2; rg = rs2; end
            else if (x64 && f == 16'h3023) begin sz = 2'd3; rg = rs2; end
            else if (fpd && f == 16'h3027) begin sz = 2'd3; fp = 1'b1; rg = rs2; end
            else if (fps && f == 16'h2027) begin sz = 2'd2; fp = 1'b1; rg = rs2; end
            else if (f == 16'h1023) begin sz = 2'd1; rg = rs2; end
            else if (x64 && c == 16'he000) begin sz = 2'd3; rg = crs; end
            else if (x64 && c == 16'he002) begin sz = 2'd3; rg = csp; end
            else if (c == 16'hc000) begin sz = 2'd2; rg = crs; end
            else if (c == 16'hc002) begin sz = 2'd2; rg = csp; end
            else if (fpd && c == 16'ha000) begin sz = 2'd3; fp = 1'b1; rg = crs; end
            else if (fpd && c == 16'ha002) begin sz = 2'd3; fp = 1'b1; rg = csp; end
            else if (!x64 && fps && c == 16'he000) begin sz = 2'd2; fp = 1'b1; rg = crs; end
            else if (!x64 && fps && c == 16'he002) begin sz = 2'd2; fp = 1'b1; rg = csp; end
            else ok = 1'b0;
        end
        n_cmd.item    = i_data;
        n_cmd.dec_ok  = ok;
        n_cmd.size    = sz;
        n_cmd.sign    = sg;
        n_cmd.fp      = fp;
        n_cmd.rreg    = rg;
        n_cmd.short_i = i_data.instr_word[1:0] != 2'b11;
    end

    assign o_stall = r_vld && i_stall;
    assign o_valid = r_vld;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

@@ src/mls_queue.sv @@
`timescale 1ns / 1ps
module mls_queue import mls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_stall = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= i_cmd;
    end
endmodule

@@ src/mls_back.sv @@
`timescale 1ns / 1ps
module mls_back import mls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    output logic o_stall,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    typedef enum logic [1:0] {ST_IDLE, ST_REG, ST_BYTE} t_state;

    t_state      r_state;
    logic        r_store;
    logic [1:0]  r_size;
    logic        r_sign;
    logic        r_fp;
    logic [4:0]  r_reg;
    logic [3:0]  r_idx;
    logic [63:0] r_buf;
    logic [63:0] r_pc;
    logic [63:0] r_addr;
    logic        r_short;
    logic        r_ovld;
    t_out        r_out;

    t_state      n_state;
    logic        n_store;
    logic [1:0]  n_size;
    logic        n_sign;
    logic        n_fp;
    logic [4:0]  n_reg;
    logic [3:0]  n_idx;
    logic [63:0] n_buf;
    logic [63:0] n_pc;
    logic [63:0] n_addr;
    logic        n_short;
    logic        n_emit;
    t_out        n_out;

    logic        take;
    logic [2:0]  bi;
    logic [3:0]  len;
    logic [5:0]  ca;
    logic [63:0] v;
    t_in         it;

    assign o_stall = r_ovld && i_stall;
    assign take    = i_valid && !o_stall;
    assign o_valid = r_ovld;
    assign o_data  = r_out;
    assign it      = i_cmd.item;

    always_comb begin
        n_state = r_state; n_store = r_store; n_size = r_size; n_sign = r_sign;
        n_fp = r_fp; n_reg = r_reg; n_idx = r_idx; n_buf = r_buf; n_pc = r_pc;
        n_addr = r_addr; n_short = r_short; n_emit = 1'b0; n_out = '0;
        bi = 3'd0; len = 4'd0; ca = 6'd0; v = 64'd0;
        case (it.req_type)
            REQ_LOAD, REQ_STORE: begin
                n_emit  = 1'b1;
                n_store = it.req_type == REQ_STORE;
                n_pc = it.instr_addr; n_addr = it.fault_addr;
                n_short = i_cmd.short_i; n_idx = 4'd0; n_buf = 64'd0;
                n_reg = 5'd0; n_fp = 1'b0; n_size = 2'd0; n_sign = 1'b0;
                n_out.out_kind = KIND_DONE;
                n_out.new_pc = it.instr_addr;
                n_state = ST_IDLE;
                if (it.fault_flag) begin
                    if (it.fault_cause == i_cfg.tlb_miss_cause) begin
                        n_out.outcome = OC_REPEAT;
                    end else begin
                        ca = it.fault_cause;
                        if (ca == CAUSE_LOAD_ACCESS) ca = CAUSE_FETCH_ACCESS;
                        else if (ca == CAUSE_LOAD_PAGE) ca = CAUSE_FETCH_PAGE;
                        n_out.outcome = OC_REDIRECT;
                        n_out.trap_cause = ca;
                        n_out.trap_value = it.instr_addr;
                    end
                end else if (!i_cmd.dec_ok) begin
                    n_out.outcome = OC_REDIRECT;
                    n_out.trap_cause = n_store ? CAUSE_STORE_MISALIGN : CAUSE_LOAD_MISALIGN;
                    n_out.trap_value = it.fault_addr;
                end else begin
                    n_size = i_cmd.size; n_sign = i_cmd.sign;
                    n_fp = i_cmd.fp; n_reg = i_cmd.rreg;
                    n_out.new_pc = 64'd0;
                    n_out.reg_index = n_reg;
                    n_out.reg_is_fp = n_fp;
                    n_out.reg_is_double = n_fp && n_size == 2'd3;
                    if (n_store) begin
                        n_state = ST_REG;
                        n_out.out_kind = KIND_RD_REG;
                    end else begin
                        n_state = ST_BYTE;
                        n_out.out_kind = KIND_RD_BYTE;
                        n_out.access_addr = it.fault_addr;
                    end
                end
            end
            REQ_REG: begin
                if (r_state == ST_REG) begin
                    n_emit = 1'b1;
                    n_buf = it.reply_data; n_idx = 4'd0; n_state = ST_BYTE;
                    n_out.out_kind = KIND_WR_BYTE;
                    n_out.access_addr = r_addr;
                    n_out.access_data = it.reply_data[7:0];
                end
            end
            default: begin
                if (r_state == ST_BYTE) begin
                    n_emit = 1'b1;
                    bi = r_idx[2:0];
                    len = 4'd1 << r_size;
                    if (it.fault_flag) begin
                        n_state = ST_IDLE;
                        n_out.out_kind = KIND_DONE;
                        n_out.new_pc = r_pc;
                        if (it.fault_cause == i_cfg.tlb_miss_cause) begin
                            n_out.outcome = OC_REPEAT;
                        end else begin
                            n_out.outcome = OC_REDIRECT;
                            n_out.trap_cause = it.fault_cause;
                            n_out.trap_value = r_addr + {61'd0, bi};
                        end
                    end else begin
                        if (!r_store) n_buf = r_buf | ({56'd0, it.reply_data[7:0]} << {bi, 3'd0});
                        n_idx = {1'b0, bi} + 4'd1;
                        if (n_idx < len) begin
                            n_out.access_addr = r_addr + {60'd0, n_idx};
                            if (r_store) begin
                                n_out.out_kind = KIND_WR_BYTE;
                                n_out.access_data = 8'(r_buf >> {n_idx[2:0], 3'd0});
                            end else begin
                                n_out.out_kind = KIND_RD_BYTE;
                            end
                        end else begin
                            n_state = ST_IDLE;
                            n_out.out_kind = KIND_DONE;
                            n_out.outcome = OC_RETIRE;
                            n_out.new_pc = r_pc + (r_short ? 64'd2 : 64'd4);
                            if (!r_store) begin
                                v = n_buf;
                                if (!r_fp) begin
                                    if (r_sign) begin
                                        case (r_size)
                                            2'd1: v = {{48{v[15]}}, v[15:0]};
                                            2'd2: v = {{32{v[31]}}, v[31:0]};
                                            default: v = v;
                                        endcase
                                    end
                                    if (!i_cfg.xlen_is_64) v = {32'd0, v[31:0]};
                                end
                                n_out.load_value = v;
                                n_out.load_write = 1'b1;
                            end
                        end
                    end
                end
            end
        endcase
        if (r_state != ST_IDLE || n_emit) begin
            if (!(it.req_type == REQ_LOAD || it.req_type == REQ_STORE)
                || i_cmd.dec_ok && !it.fault_flag) begin
                n_out.reg_index = n_reg;
                n_out.reg_is_fp = n_fp;
                n_out.reg_is_double = n_fp && n_size == 2'd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_store <= 1'b0; r_size <= 2'd0; r_sign <= 1'b0;
            r_fp <= 1'b0; r_reg <= 5'd0; r_idx <= 4'd0; r_buf <= 64'd0;
            r_pc <= 64'd0; r_addr <= 64'd0; r_short <= 1'b0; r_ovld <= 1'b0;
        end else begin
            if (!o_stall) r_ovld <= take && n_emit;
            if (take) begin
                r_state <= n_state; r_store <= n_store; r_size <= n_size;
                r_sign <= n_sign; r_fp <= n_fp; r_reg <= n_reg; r_idx <= n_idx;
                r_buf <= n_buf; r_pc <= n_pc; r_addr <= n_addr; r_short <= n_short;
            end
        end
        if (take && n_emit) r_out <= n_out;
    end
endmodule

@@ src/misaligned_load_store_splitter_unit.sv @@
`timescale 1ns / 1ps
// path from input acceptance to result valid: front register, queue, back register
// throughput: one transaction per cycle when not stalled; back stage: one per cycle
// the byte loop in the back stage advances one byte per reply transaction
// reset: synchronous active low; clears phase, queue and config to defaults
module misaligned_load_store_splitter_unit import mls_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg r_cfg;
    logic fv, fs, qv, qs;
    t_cmd fc, qc;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.xlen_is_64 <= 1'b1;
            r_cfg.fp_mode <= 2'd2;
            r_cfg.tlb_miss_cause <= 6'd24;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                ADDR_XLEN: r_cfg.xlen_is_64 <= pwdata[0];
                ADDR_FP:   r_cfg.fp_mode <= pwdata[1:0];
                ADDR_TLB:  r_cfg.tlb_miss_cause <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ADDR_XLEN: prdata = {31'd0, r_cfg.xlen_is_64};
            ADDR_FP:   prdata = {30'd0, r_cfg.fp_mode};
            ADDR_TLB:  prdata = {26'd0, r_cfg.tlb_miss_cause};
            default:   prdata = 32'd0;
        endcase
    end

    mls_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(fv), .i_stall(fs), .o_cmd(fc)
    );

    mls_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(fv), .o_stall(fs), .i_cmd(fc),
        .o_valid(qv), .i_stall(qs), .o_cmd(qc)
    );

    mls_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(qv), .o_stall(qs), .i_cmd(qc),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );
endmodule

@@ src/mls_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mls_checker import mls_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data,
    input logic pready
);
    logic lw_ok;
    logic req_ok;

    assign lw_ok  = o_data.out_kind == KIND_DONE && o_data.outcome == OC_RETIRE;
    assign req_ok = o_data.outcome == OC_RETIRE && o_data.new_pc == 64'd0;

    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `CHK_IMPLY(a_ready, i_clk, i_rst_n, 1'b1, pready)
    `CHK_IMPLY(a_lw, i_clk, i_rst_n, o_valid && o_data.load_write, lw_ok)
    `CHK_IMPLY(a_oc, i_clk, i_rst_n, o_valid && o_data.out_kind != KIND_DONE, req_ok)
endmodule

bind misaligned_load_store_splitter_unit mls_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid),
    .i_stall(i_stall), .o_data(o_data), .pready(pready)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import mls_pkg::*;

    // opcode match values for the full-size and compressed forms
    localparam logic [31:0] MASK_FULL = 32'h707f;
    localparam logic [31:0] MASK_C    = 32'he003;
    localparam logic [31:0] OP_LW  = 32'h2003, OP_LD = 32'h3003, OP_LWU = 32'h6003;
    localparam logic [31:0] OP_FLD = 32'h3007, OP_FLW = 32'h2007;
    localparam logic [31:0] OP_LH  = 32'h1003, OP_LHU = 32'h5003;
    localparam logic [31:0] OP_SW  = 32'h2023, OP_SD = 32'h3023;
    localparam logic [31:0] OP_FSD = 32'h3027, OP_FSW = 32'h2027, OP_SH = 32'h1023;
    localparam logic [31:0] C_LD = 32'h6000, C_LDSP = 32'h6002;
    localparam logic [31:0] C_LW = 32'h4000, C_LWSP = 32'h4002;
    localparam logic [31:0] C_FLD = 32'h2000, C_FLDSP = 32'h2002;
    localparam logic [31:0] C_SD = 32'he000, C_SDSP = 32'he002;
    localparam logic [31:0] C_SW = 32'hc000, C_SWSP = 32'hc002;
    localparam logic [31:0] C_FSD = 32'ha000, C_FSDSP = 32'ha002;
    localparam logic [31:0] LOAD_OPS [14] = '{OP_LW, OP_LD, OP_LWU, OP_FLD, OP_FLW, OP_LH,
        OP_LHU, C_LD, C_LDSP, C_LW, C_LWSP, C_FLD, C_FLDSP, OP_LH};
    localparam logic [31:0] STORE_OPS [14] = '{OP_SW, OP_SD, OP_FSD, OP_FSW, OP_SH,
        C_SD, C_SDSP, C_SW, C_SWSP, C_FSD, C_FSDSP, OP_SH, OP_SW, C_SW};

    localparam logic [1:0] PH_IDLE = 2'd0, PH_REG = 2'd1, PH_BYTE = 2'd2;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 12;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall, o_valid, i_stall;
    t_in         i_data;
    t_out        o_data;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    misaligned_load_store_splitter_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // shadow of the block's configuration and access state
    logic        cfg_x64;
    logic [1:0]  cfg_fp;
    logic [5:0]  cfg_tlb;
    logic [1:0]  acc_phase, acc_size;
    logic        acc_store, acc_sign, acc_fp, acc_short;
    logic [4:0]  acc_reg;
    logic [3:0]  acc_byte;
    logic [63:0] acc_buf, acc_pc, acc_addr;

    t_out expected_results[$];
    int   mismatches, items_sent, idle_cycles, burst_left;

    function automatic bit decode_instr(input logic [31:0] w, input bit st,
                                        output logic [1:0] sz, output logic sg,
                                        output logic fp, output logic [4:0] r);
        logic [31:0] f, c;
        logic [4:0] rd, rs2, crs, csp;
        bit x64, fps, fpd;
        f = w & MASK_FULL; c = w & MASK_C;
        rd = w[11:7]; rs2 = w[24:20]; crs = 5'd8 + w[4:2]; csp = w[6:2];
        x64 = cfg_x64; fps = cfg_fp != 0; fpd = cfg_fp >= 2;
        sg = 0; fp = 0; sz = 0; r = 0;
        if (!st) begin
            if (f == OP_LW) begin sz = 2; sg = 1; r = rd; end
            else if (x64 && f == OP_LD) begin sz = 3; sg = 1; r = rd; end
            else if (x64 && f == OP_LWU) begin sz = 2; r = rd; end
            else if (fpd && f == OP_FLD) begin sz = 3; fp = 1; r = rd; end
            else if (fps && f == OP_FLW) begin sz = 2; fp = 1; r = rd; end
            else if (f == OP_LH) begin sz = 1; sg = 1; r = rd; end
            else if (f == OP_LHU) begin sz = 1; r = rd; end
            else if (x64 && c == C_LD) begin sz = 3; sg = 1; r = crs; end
            else if (x64 && c == C_LDSP && rd != 0) begin sz = 3; sg = 1; r = rd; end
            else if (c == C_LW) begin sz = 2; sg = 1; r = crs; end
            else if (c == C_LWSP && rd != 0) begin sz = 2; sg = 1; r = rd; end
            else if (fpd && c == C_FLD) begin sz = 3; fp = 1; r = crs; end
            else if (fpd && c == C_FLDSP) begin sz = 3; fp = 1; r = rd; end
            else if (!x64 && fps && c == C_LD) begin sz = 2; fp = 1; r = crs; end
            else if (!x64 && fps && c == C_LDSP) begin sz = 2; fp = 1; r = rd; end
            else return 0;
        end else begin
            if (f == OP_SW) begin sz = 2; r = rs2; end
            else if (x64 && f == OP_SD) begin sz = 3; r = rs2; end
            else if (fpd && f == OP_FSD) begin sz = 3; fp = 1; r = rs2; end
            else if (fps && f == OP_FSW) begin sz = 2; fp = 1; r = rs2; end
            else if (f == OP_SH) begin sz = 1; r = rs2; end
            else if (x64 && c == C_SD) begin sz = 3; r = crs; end
            else if (x64 && c == C_SDSP) begin sz = 3; r = csp; end
            else if (c == C_SW) begin sz = 2; r = crs; end
            else if (c == C_SWSP) begin sz = 2; r = csp; end
            else if (fpd && c == C_FSD) begin sz = 3; fp = 1; r = crs; end
            else if (fpd && c == C_FSDSP) begin sz = 3; fp = 1; r = csp; end
            else if (!x64 && fps && c == C_SD) begin sz = 2; fp = 1; r = crs; end
            else if (!x64 && fps && c == C_SDSP) begin sz = 2; fp = 1; r = csp; end
            else return 0;
        end
        return 1;
    endfunction

    function automatic void fill_regs(inout t_out o);
        o.reg_index = acc_reg;
        o.reg_is_fp = acc_fp;
        o.reg_is_double = acc_fp && acc_size == 3;
    endfunction

    function automatic void finish_access(inout t_out o, input logic [1:0] oc,
                                          input logic [63:0] pc, input logic [5:0] cause,
                                          input logic [63:0] tval);
        o.out_kind = KIND_DONE; fill_regs(o);
        o.outcome = oc; o.new_pc = pc; o.trap_cause = cause; o.trap_value = tval;
        acc_phase = PH_IDLE;
    endfunction

    function automatic void byte_request(inout t_out o);
        logic [2:0] i;
        i = acc_byte[2:0];
        fill_regs(o);
        o.access_addr = acc_addr + 64'(i);
        if (acc_store) begin
            o.out_kind = KIND_WR_BYTE;
            o.access_data = acc_buf[8*i +: 8];
        end else begin
            o.out_kind = KIND_RD_BYTE;
        end
    endfunction

    // advances the shadow state for one accepted transaction
    function automatic bit predict_access(input t_in d, output t_out o);
        logic [31:0] w;
        logic [5:0] cause;
        logic [1:0] sz;
        logic sg, fp;
        logic [4:0] r;
        int len;
        logic [2:0] i;
        logic [63:0] v;
        o = '0;
        w = d.instr_word; cause = d.fault_cause;
        if (d.req_type == REQ_LOAD || d.req_type == REQ_STORE) begin
            acc_store = d.req_type == REQ_STORE;
            acc_pc = d.instr_addr; acc_addr = d.fault_addr;
            acc_short = w[1:0] != 2'b11;
            if (acc_short) w[31:16] = 0;
            acc_byte = 0; acc_buf = 0;
            acc_reg = 0; acc_fp = 0; acc_size = 0; acc_sign = 0;
            if (d.fault_flag) begin
                if (cause == cfg_tlb) begin
                    finish_access(o, OC_REPEAT, acc_pc, 0, 0);
                    return 1;
                end
                if (cause == CAUSE_LOAD_ACCESS) cause = CAUSE_FETCH_ACCESS;
                else if (cause == CAUSE_LOAD_PAGE) cause = CAUSE_FETCH_PAGE;
                finish_access(o, OC_REDIRECT, acc_pc, cause, acc_pc);
                return 1;
            end
            if (!decode_instr(w, acc_store, sz, sg, fp, r)) begin
                finish_access(o, OC_REDIRECT, acc_pc,
                    acc_store ? CAUSE_STORE_MISALIGN : CAUSE_LOAD_MISALIGN, acc_addr);
                return 1;
            end
            acc_size = sz; acc_sign = sg; acc_fp = fp; acc_reg = r;
            if (acc_store) begin
                acc_phase = PH_REG; o.out_kind = KIND_RD_REG; fill_regs(o);
                return 1;
            end
            acc_phase = PH_BYTE; byte_request(o);
            return 1;
        end
        if (d.req_type == REQ_REG) begin
            if (acc_phase != PH_REG) return 0;
            acc_buf = d.reply_data; acc_byte = 0; acc_phase = PH_BYTE;
            byte_request(o);
            return 1;
        end
        if (acc_phase != PH_BYTE) return 0;
        len = 1 << acc_size;
        i = acc_byte[2:0];
        if (d.fault_flag) begin
            if (cause == cfg_tlb) finish_access(o, OC_REPEAT, acc_pc, 0, 0);
            else finish_access(o, OC_REDIRECT, acc_pc, cause, acc_addr + 64'(i));
            return 1;
        end
        if (!acc_store) acc_buf[8*i +: 8] = d.reply_data[7:0];
        acc_byte = {1'b0, i} + 4'd1;
        if (acc_byte < len) begin
            byte_request(o);
            return 1;
        end
        finish_access(o, OC_RETIRE, acc_pc + (acc_short ? 64'd2 : 64'd4), 0, 0);
        if (!acc_store) begin
            v = acc_buf;
            if (!acc_fp) begin
                if (acc_sign && len < 8 && v[8*len-1]) v = v | (~64'd0 << (8*len));
                if (!cfg_x64) v[63:32] = 0;
            end
            o.load_value = v; o.load_write = 1;
        end
        return 1;
    endfunction

    task automatic send_item(input t_in d);
        t_out o;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
        end
        i_valid <= 1'b1;
        i_data <= d;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        burst_left--;
        items_sent++;
        if (predict_access(d, o)) expected_results.push_back(o);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        go_idle();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            ADDR_XLEN: cfg_x64 = val[0];
            ADDR_FP:   cfg_fp = val[1:0];
            ADDR_TLB:  cfg_tlb = val[5:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic x64, input logic [1:0] fpm, input logic [5:0] tlb);
        wait_drained();
        reg_write(ADDR_XLEN, {31'd0, x64});
        reg_write(ADDR_FP, {30'd0, fpm});
        reg_write(ADDR_TLB, {26'd0, tlb});
    endtask

    function automatic t_in rand_item();
        t_in d;
        d.req_type = $urandom_range(0, 3);
        d.instr_word = $urandom;
        d.instr_addr = {$urandom, $urandom};
        d.fault_addr = {$urandom, $urandom};
        d.fault_flag = $urandom_range(0, 1);
        d.fault_cause = $urandom;
        d.reply_data = {$urandom, $urandom};
        return d;
    endfunction

    function automatic logic [31:0] make_instr(input bit st, input logic [31:0] op);
        logic [31:0] w;
        w = $urandom;
        if (op[1:0] == 2'b11) return (w & ~MASK_FULL) | op;
        return (w & ~MASK_C) | op;
    endfunction

    task automatic send_trap(input bit st, input logic [31:0] w, input logic flag,
                             input logic [5:0] cause, input logic [63:0] pc,
                             input logic [63:0] addr);
        t_in d;
        d = rand_item();
        d.req_type = st ? REQ_STORE : REQ_LOAD;
        d.instr_word = w; d.fault_flag = flag; d.fault_cause = cause;
        d.instr_addr = pc; d.fault_addr = addr;
        send_item(d);
    endtask

    // replies to register and byte requests until the access ends; fault_pct picks faulting replies
    task automatic answer_access(input int fault_pct);
        t_in d;
        while (acc_phase != PH_IDLE) begin
            d = rand_item();
            if ($urandom_range(0, 99) < 3) begin
                d.req_type = acc_phase == PH_REG ? REQ_BYTE : REQ_REG;
            end else begin
                d.req_type = acc_phase == PH_REG ? REQ_REG : REQ_BYTE;
                d.fault_flag = $urandom_range(0, 99) < fault_pct;
                if ($urandom_range(0, 1)) d.fault_cause = cfg_tlb;
            end
            if ($urandom_range(0, 99) < 2) d.req_type = $urandom_range(0, 1);
            send_item(d);
        end
    endtask

    task automatic one_access(input int fault_pct);
        bit st;
        logic [31:0] w;
        logic [5:0] cause;
        st = $urandom_range(0, 1);
        w = st ? make_instr(1, STORE_OPS[$urandom_range(0, 13)])
               : make_instr(0, LOAD_OPS[$urandom_range(0, 13)]);
        if ($urandom_range(0, 9) == 0) w = $urandom;
        cause = $urandom_range(0, 3) == 0 ? cfg_tlb : 6'($urandom);
        send_trap(st, w, $urandom_range(0, 99) < fault_pct, cause,
                  {$urandom, $urandom}, {$urandom, $urandom});
        answer_access(fault_pct);
    endtask

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        // wide load at the top of memory wraps the byte address
        send_trap(0, make_instr(0, OP_LD), 0, 0, ones, ones);
        answer_access(0);
        // compressed store from the stack pointer form, pc wraps on retire
        send_trap(1, make_instr(1, C_SDSP), 0, 0, ones - 1, 64'd0);
        answer_access(0);
        // fetch faults: tlb miss, access and page rewrites, undecodable word
        send_trap(0, 32'd0, 1, cfg_tlb, 64'd0, ones);
        send_trap(1, 32'd0, 1, CAUSE_LOAD_ACCESS, ones, 64'd0);
        send_trap(0, 32'd0, 1, CAUSE_LOAD_PAGE, 64'h1000, 64'd3);
        send_trap(1, 32'hffff_ffff, 0, 0, 64'h2000, 64'd5);
        // faulting byte access midway, then an abort by a fresh trap
        send_trap(0, make_instr(0, OP_LH), 0, 0, 64'h40, 64'h41);
        answer_access(50);
        send_trap(0, make_instr(0, OP_LW), 0, 0, 64'h80, 64'h83);
        send_trap(1, make_instr(1, OP_SH), 0, 0, 64'h84, 64'h85);
        answer_access(0);
    endtask

    task automatic test_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) one_access($urandom_range(0, 1) ? 0 : 15);
    endtask

    task automatic test_config_sweep();
        set_config(1'b0, 2'd0, 6'd0);
        test_random(120);
        set_config(1'b1, 2'd1, 6'd63);
        test_random(120);
        set_config(1'b0, 2'd2, 6'($urandom));
        test_random(120);
        set_config(1'b1, 2'd3, 6'd24);
        test_random(120);
        // sender holds off until everything is back
        wait_drained();
        test_random(240);
    endtask

    // receiver stall pattern: free, random and heavy stretches
    int stall_left;
    int stall_kind;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left <= $urandom_range(10, 80);
            stall_kind <= $urandom_range(0, 2);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_kind)
            0: i_stall <= 1'b0;
            1: i_stall <= $urandom_range(0, 1);
            default: i_stall <= $urandom_range(0, 3) != 0;
        endcase
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_data);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_data !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch\n  expected %p\n  actual   %p", exp_r, o_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_data = '0; i_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        stall_left = 0; stall_kind = 0; idle_cycles = 0;
        mismatches = 0; items_sent = 0; burst_left = 5;
        cfg_x64 = 1; cfg_fp = 2; cfg_tlb = 24;
        acc_phase = PH_IDLE; acc_store = 0; acc_size = 0; acc_sign = 0; acc_fp = 0;
        acc_reg = 0; acc_byte = 0; acc_buf = 0; acc_pc = 0; acc_addr = 0; acc_short = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        wait_drained();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
